// File: src/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// shared types, widths and the saturating limit function of the pid regulator
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int DATA_W    = 32;                 // q16.16 data and register width
   localparam int FRAC_BITS = 16;                 // fraction bits of the fixed point
   localparam int ERR_W     = DATA_W + 1;         // exact difference of two data words
   localparam int PROD_W    = DATA_W + ERR_W;     // exact gain times difference
   localparam int TERM_W    = PROD_W - FRAC_BITS; // product after the floor shift
   localparam int SUM_W     = TERM_W + 2;         // three-term sum, never overflows
   localparam int CSR_IDX_W = 3;

   localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RST = DATA_W'(1000);

   typedef enum logic [0:0] {
      REQ_COMPUTE = 1'b0,
      REQ_MODE    = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN       = 3'd0,
      CSR_KI_STEP       = 3'd1,
      CSR_KD_STEP       = 3'd2,
      CSR_OUT_MIN       = 3'd3,
      CSR_OUT_MAX       = 3'd4,
      CSR_SAMPLE_PERIOD = 3'd5
   } csr_index_type;

   // upper limit is tested first, so inverted limits give out_max or out_min
   function automatic logic signed [DATA_W-1:0] limit_value(
      input logic signed [SUM_W-1:0]  value,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi
   );
      logic signed [DATA_W-1:0] result;
      if (value > SUM_W'(hi)) begin
         result = hi;
      end else if (value < SUM_W'(lo)) begin
         result = lo;
      end else begin
         result = value[DATA_W-1:0];
      end
      return result;
   endfunction

endpackage

// File: src/pid_controller_bumpless.sv
// ----------------------------------------------------------------------------
// pid_controller_bumpless
// q16.16 pid regulator, derivative on measurement, clamped integral and output
// ----------------------------------------------------------------------------
// usage
//   req_* channel: one beat per request. req_type selects a compute beat
//   (setpoint, measurement, time_now) or a mode beat (auto_mode, measurement
//   and init_output seed the state when entering automatic).
//   rsp_* channel: exactly one beat per request, rsp_drive is the new or
//   held output and rsp_updated flags a fresh computation.
//   csr_* port: plain register writes, only while no request is in flight.
// timing
//   a request is held in the input register, then in the result register
//   that drives rsp_*. one beat per cycle is sustained while rsp_stall is
//   low: the whole update (three multipliers in parallel, two saturating
//   sums) sits between the input and result regs.
// reset
//   synchronous; clears both valid flags, the controller state (manual mode)
//   and the configuration registers to their defaults (sample period 1000 ms).
// stall
//   a stalled result holds; one more request is taken into the input register
//   behind it, then req_stall rises until the result beat is taken.
// ----------------------------------------------------------------------------
module pid_controller_bumpless
   import pidc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [DATA_W-1:0]    req_setpoint,
   input  logic signed [DATA_W-1:0]    req_measurement,
   input  logic        [DATA_W-1:0]    req_time_now,
   input  logic                        req_auto_mode,
   input  logic signed [DATA_W-1:0]    req_init_output,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_drive,
   output logic                        rsp_updated,
   // register writes
   input  logic                        csr_wr_en,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic signed [DATA_W-1:0] kp_gain_ff;
   logic signed [DATA_W-1:0] ki_step_ff;
   logic signed [DATA_W-1:0] kd_step_ff;
   logic signed [DATA_W-1:0] out_min_ff;
   logic signed [DATA_W-1:0] out_max_ff;
   logic        [DATA_W-1:0] sample_period_ff;

   // input register
   logic                     in_valid_ff;
   req_kind_type             in_kind_ff;
   logic signed [DATA_W-1:0] in_setpoint_ff;
   logic signed [DATA_W-1:0] in_meas_ff;
   logic        [DATA_W-1:0] in_time_ff;
   logic                     in_auto_ff;
   logic signed [DATA_W-1:0] in_init_ff;

   // controller state
   logic signed [DATA_W-1:0] integral_ff, integral_in;
   logic signed [DATA_W-1:0] prev_meas_ff, prev_meas_in;
   logic signed [DATA_W-1:0] held_out_ff, held_out_in;
   logic        [DATA_W-1:0] last_time_ff, last_time_in;
   logic                     automatic_ff, automatic_in;

   // result register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_drive_ff;
   logic                     rsp_updated_ff, updated_in;

   // handshake: the input register moves on when the result slot is free
   logic take_result;
   logic advance;

   assign take_result = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && take_result;
   assign req_stall   = in_valid_ff && !take_result;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_updated = rsp_updated_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff       <= '0;
         ki_step_ff       <= '0;
         kd_step_ff       <= '0;
         out_min_ff       <= '0;
         out_max_ff       <= '0;
         sample_period_ff <= SAMPLE_PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_GAIN:       kp_gain_ff       <= csr_wdata;
            CSR_KI_STEP:       ki_step_ff       <= csr_wdata;
            CSR_KD_STEP:       kd_step_ff       <= csr_wdata;
            CSR_OUT_MIN:       out_min_ff       <= csr_wdata;
            CSR_OUT_MAX:       out_max_ff       <= csr_wdata;
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata;
            default: ;  // unused indexes are ignored
         endcase
      end
   end

   // ------------------------------------------------------------ input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff     <= req_kind_type'(req_type);
         in_setpoint_ff <= req_setpoint;
         in_meas_ff     <= req_measurement;
         in_time_ff     <= req_time_now;
         in_auto_ff     <= req_auto_mode;
         in_init_ff     <= req_init_output;
      end
   end

   // ---------------------------------------------------------------- datapath
   logic signed [ERR_W-1:0]  err_val;
   logic signed [ERR_W-1:0]  dmeas_val;
   logic signed [PROD_W-1:0] kp_prod, ki_prod, kd_prod;
   logic signed [TERM_W-1:0] kp_term, ki_term, kd_term;
   logic signed [SUM_W-1:0]  integ_sum, out_sum;
   logic signed [DATA_W-1:0] integ_new, out_new, seed_integ;
   logic        [DATA_W-1:0] elapsed;
   logic                     period_done;

   // exact differences, one bit wider than the operands
   assign err_val   = ERR_W'(in_setpoint_ff) - ERR_W'(in_meas_ff);
   assign dmeas_val = ERR_W'(in_meas_ff) - ERR_W'(prev_meas_ff);

   // exact products; dropping the low bits is a floor shift
   assign kp_prod = PROD_W'(kp_gain_ff) * PROD_W'(err_val);
   assign ki_prod = PROD_W'(ki_step_ff) * PROD_W'(err_val);
   assign kd_prod = PROD_W'(kd_step_ff) * PROD_W'(dmeas_val);
   assign kp_term = kp_prod[PROD_W-1:FRAC_BITS];
   assign ki_term = ki_prod[PROD_W-1:FRAC_BITS];
   assign kd_term = kd_prod[PROD_W-1:FRAC_BITS];

   // anti-windup: integral saturates at the output limits
   assign integ_sum = SUM_W'(integral_ff) + SUM_W'(ki_term);
   assign integ_new = limit_value(integ_sum, out_min_ff, out_max_ff);

   // derivative on measurement is subtracted
   assign out_sum = SUM_W'(kp_term) + SUM_W'(integ_new) - SUM_W'(kd_term);
   assign out_new = limit_value(out_sum, out_min_ff, out_max_ff);

   assign seed_integ = limit_value(SUM_W'(in_init_ff), out_min_ff, out_max_ff);

   // wrapping millisecond timer
   assign elapsed     = in_time_ff - last_time_ff;
   assign period_done = elapsed >= sample_period_ff;

   always_comb begin
      integral_in  = integral_ff;
      prev_meas_in = prev_meas_ff;
      held_out_in  = held_out_ff;
      last_time_in = last_time_ff;
      automatic_in = automatic_ff;
      updated_in   = 1'b0;
      unique case (in_kind_ff)
         REQ_MODE: begin
            // bumpless transfer on the manual to automatic edge
            if (in_auto_ff && !automatic_ff) begin
               prev_meas_in = in_meas_ff;
               integral_in  = seed_integ;
            end
            automatic_in = in_auto_ff;
         end
         REQ_COMPUTE: begin
            if (automatic_ff && period_done) begin
               integral_in  = integ_new;
               held_out_in  = out_new;
               prev_meas_in = in_meas_ff;
               last_time_in = in_time_ff;
               updated_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff  <= '0;
         prev_meas_ff <= '0;
         held_out_ff  <= '0;
         last_time_ff <= '0;
         automatic_ff <= 1'b0;
      end else if (advance) begin
         integral_ff  <= integral_in;
         prev_meas_ff <= prev_meas_in;
         held_out_ff  <= held_out_in;
         last_time_ff <= last_time_in;
         automatic_ff <= automatic_in;
      end
   end

   // ----------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take_result) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff   <= held_out_in;
         rsp_updated_ff <= updated_in;
      end
   end

endmodule

// File: src/pidc_checker.sv
// ----------------------------------------------------------------------------
// pidc_checker
// port-level checks of the pid regulator, bound to the top level
// ----------------------------------------------------------------------------
module pidc_checker
   import pidc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_drive,
   input logic                     rsp_updated
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // requests back up only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with result slot empty");

   // an accepted request reaches the result side if rsp_stall is low while it sits in the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not produce a result");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_drive) && $stable(rsp_updated))
      else $error("stalled result beat changed");

endmodule

bind pid_controller_bumpless pidc_checker u_pidc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_drive   (rsp_drive),
   .rsp_updated (rsp_updated)
);

// File: dv/tb_pid_controller_bumpless.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_bumpless
// self-checking bench for the q16.16 pid regulator with bumpless transfer
// ----------------------------------------------------------------------------
// request beats are pushed through the req_* channel with random gaps, and
// result beats are taken with random stalls. each accepted request runs
// through an in-bench copy of the regulator, whose expected result is queued
// and compared field by field with the next result beat. directed tests hit the
// mode, sample-time, wrap, operand and limit corners first, then random traffic
// over several register settings; a long result hold-off then fills the block.
// ----------------------------------------------------------------------------
module tb_pid_controller_bumpless;
   import pidc_pkg::*;

   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam int RANDOM_PHASES    = 10;
   localparam int BEATS_PER_PHASE  = 150;
   localparam int HOLD_OFF_CYCLES  = 300;

   typedef struct {
      req_kind_type             kind;
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] measurement;
      logic        [DATA_W-1:0] time_now;
      logic                     auto_mode;
      logic signed [DATA_W-1:0] init_output;
   } pid_request_type;

   typedef struct {
      logic signed [DATA_W-1:0] drive;
      logic                     updated;
   } drive_beat_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic                        req_type        = 1'b0;
   logic signed [DATA_W-1:0]    req_setpoint    = '0;
   logic signed [DATA_W-1:0]    req_measurement = '0;
   logic        [DATA_W-1:0]    req_time_now    = '0;
   logic                        req_auto_mode   = 1'b0;
   logic signed [DATA_W-1:0]    req_init_output = '0;

   // result channel
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]    rsp_drive;
   logic                        rsp_updated;

   // register write port
   logic                        csr_wr_en = 1'b0;
   logic        [CSR_IDX_W-1:0] csr_index = '0;
   logic        [DATA_W-1:0]    csr_wdata = '0;

   // bench copy of the registers, reset values
   logic signed [DATA_W-1:0] cfg_kp     = '0;
   logic signed [DATA_W-1:0] cfg_ki     = '0;
   logic signed [DATA_W-1:0] cfg_kd     = '0;
   logic signed [DATA_W-1:0] cfg_lo     = '0;
   logic signed [DATA_W-1:0] cfg_hi     = '0;
   logic        [DATA_W-1:0] cfg_period = DATA_W'(1000);

   // bench copy of the regulator state, all zero and manual after reset
   logic signed [DATA_W-1:0] ctl_integral  = '0;
   logic signed [DATA_W-1:0] ctl_prev_meas = '0;
   logic signed [DATA_W-1:0] ctl_held      = '0;
   logic        [DATA_W-1:0] ctl_last_time = '0;
   logic                     ctl_auto      = 1'b0;

   // expected result beats, oldest first
   drive_beat_type pending_drives[$];

   // traffic shaping
   bit              idle_on  = 1'b1;
   logic            hold_off = 1'b0;
   int unsigned     rx_wait  = 0;
   logic [DATA_W-1:0] ms_now = '0;

   // bookkeeping
   int mismatches         = 0;
   int beats_sent         = 0;
   int beats_checked      = 0;
   int mode_beats         = 0;
   int fresh_updates      = 0;
   int settings_loaded    = 0;
   int input_stall_cycles = 0;

   pid_controller_bumpless DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_setpoint    (req_setpoint),
      .req_measurement (req_measurement),
      .req_time_now    (req_time_now),
      .req_auto_mode   (req_auto_mode),
      .req_init_output (req_init_output),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_updated     (rsp_updated),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // upper limit wins, so inverted limits collapse to out_max or out_min
   function automatic logic signed [DATA_W-1:0] clamp_to_limits(input longint v);
      if (v > longint'(cfg_hi)) return cfg_hi;
      if (v < longint'(cfg_lo)) return cfg_lo;
      return DATA_W'(v);
   endfunction

   function automatic drive_beat_type advance_regulator(input pid_request_type rq);
      drive_beat_type    res;
      logic [DATA_W-1:0] elapsed;
      longint            err;
      longint            dmeas;
      longint            acc;
      res.updated = 1'b0;
      if (rq.kind == REQ_MODE) begin
         // bumpless entry: seed only on a manual to automatic change
         if (rq.auto_mode && !ctl_auto) begin
            ctl_prev_meas = rq.measurement;
            ctl_integral  = clamp_to_limits(longint'(rq.init_output));
         end
         ctl_auto = rq.auto_mode;
         mode_beats++;
      end else if (ctl_auto) begin
         // wrapping millisecond difference
         elapsed = rq.time_now - ctl_last_time;
         if (elapsed >= cfg_period) begin
            err   = longint'(rq.setpoint) - longint'(rq.measurement);
            dmeas = longint'(rq.measurement) - longint'(ctl_prev_meas);
            // products fit in 64 bits; >>> on signed floors toward minus infinity
            ctl_integral = clamp_to_limits(longint'(ctl_integral)
                                           + ((longint'(cfg_ki) * err) >>> FRAC_BITS));
            acc = ((longint'(cfg_kp) * err) >>> FRAC_BITS) + longint'(ctl_integral)
                  - ((longint'(cfg_kd) * dmeas) >>> FRAC_BITS);
            ctl_held      = clamp_to_limits(acc);
            ctl_prev_meas = rq.measurement;
            ctl_last_time = rq.time_now;
            res.updated   = 1'b1;
            fresh_updates++;
         end
      end
      res.drive = ctl_held;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic signed [DATA_W-1:0] pick_q16();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return Q_MIN;
      if (r == 1) return Q_MAX;
      if (r == 2) return '0;
      if (r < 8)  return $urandom;
      // small values around zero, within about +-16.0
      return DATA_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_gain();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return Q_MIN;
      if (r == 1) return Q_MAX;
      if (r == 2) return '0;
      if (r == 3) return Q_ONE;
      if (r < 9)  return $urandom;
      // modest gains, within about +-4.0
      return DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
   endfunction

   function automatic logic [DATA_W-1:0] pick_period();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 1;
      if (r == 1) return 32'hffff_ffff;
      if (r < 5)  return $urandom_range(1, 2000);
      if (r == 5) return $urandom;
      return $urandom_range(1, 20);
   endfunction

   // unused fields carry random bits
   function automatic pid_request_type make_compute(input logic signed [DATA_W-1:0] sp,
                                                    input logic signed [DATA_W-1:0] meas,
                                                    input logic [DATA_W-1:0] t);
      pid_request_type rq;
      rq.kind        = REQ_COMPUTE;
      rq.setpoint    = sp;
      rq.measurement = meas;
      rq.time_now    = t;
      rq.auto_mode   = $urandom_range(0, 1);
      rq.init_output = $urandom;
      return rq;
   endfunction

   function automatic pid_request_type make_mode(input logic want_auto,
                                                 input logic signed [DATA_W-1:0] meas,
                                                 input logic signed [DATA_W-1:0] init);
      pid_request_type rq;
      rq.kind        = REQ_MODE;
      rq.setpoint    = $urandom;
      rq.measurement = meas;
      rq.time_now    = $urandom;
      rq.auto_mode   = want_auto;
      rq.init_output = init;
      return rq;
   endfunction

   // mostly well-formed control traffic: timestamps advance around the sample
   // period, with occasional mode changes and some fully random beats
   function automatic pid_request_type draw_request();
      pid_request_type   rq;
      int unsigned       pick;
      int unsigned       r;
      logic [DATA_W-1:0] step;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         rq = make_mode(1'b0, pick_q16(), pick_q16());
      end else if (pick < 12) begin
         rq = make_mode(1'b1, pick_q16(), pick_q16());
      end else if (pick < 16) begin
         rq.kind        = req_kind_type'($urandom_range(0, 1));
         rq.setpoint    = $urandom;
         rq.measurement = $urandom;
         rq.time_now    = $urandom;
         rq.auto_mode   = $urandom_range(0, 1);
         rq.init_output = $urandom;
      end else begin
         r = $urandom_range(0, 19);
         if (r < 5) begin
            step = (cfg_period == 0) ? '0 : DATA_W'($urandom_range(0, cfg_period - 1));
         end else if (r < 13) begin
            step = cfg_period;
         end else if (r < 18) begin
            step = cfg_period + $urandom_range(0, 50);
         end else begin
            step = $urandom;
         end
         ms_now = ms_now + step;
         rq = make_compute(pick_q16(), pick_q16(), ms_now);
      end
      return rq;
   endfunction

   // ---------------------------------------------------------------- channel tasks

   task automatic note_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // all six registers, back to back; only called with nothing in flight
   task automatic load_settings(input logic signed [DATA_W-1:0] kp,
                                input logic signed [DATA_W-1:0] ki,
                                input logic signed [DATA_W-1:0] kd,
                                input logic signed [DATA_W-1:0] lo,
                                input logic signed [DATA_W-1:0] hi,
                                input logic [DATA_W-1:0] period);
      write_reg(CSR_KP_GAIN, kp);
      write_reg(CSR_KI_STEP, ki);
      write_reg(CSR_KD_STEP, kd);
      write_reg(CSR_OUT_MIN, lo);
      write_reg(CSR_OUT_MAX, hi);
      write_reg(CSR_SAMPLE_PERIOD, period);
      csr_wr_en  <= 1'b0;
      cfg_kp     = kp;
      cfg_ki     = ki;
      cfg_kd     = kd;
      cfg_lo     = lo;
      cfg_hi     = hi;
      cfg_period = period;
      settings_loaded++;
   endtask

   // valid stays up across back-to-back beats, it only drops for a gap
   task automatic send_beat(input pid_request_type rq);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= rq.kind;
      req_setpoint    <= rq.setpoint;
      req_measurement <= rq.measurement;
      req_time_now    <= rq.time_now;
      req_auto_mode   <= rq.auto_mode;
      req_init_output <= rq.init_output;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_drives.push_back(advance_regulator(rq));
      beats_sent++;
   endtask

   // drop valid and wait until every expected beat has come back
   task automatic settle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_drives.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   // receiver: per-beat random wait, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait   = 0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rx_wait = idle_on ? $urandom_range(0, 11) : 0;
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each taken result beat with the oldest expectation
   always @(posedge clock) begin
      drive_beat_type want;
      if (!reset) begin
         if (req_valid && req_stall) begin
            input_stall_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_drives.size() == 0) begin
               note_mismatch($sformatf("result beat with nothing expected, drive %h",
                                       rsp_drive));
            end else begin
               want = pending_drives.pop_front();
               beats_checked++;
               if (rsp_drive !== want.drive) begin
                  note_mismatch($sformatf("beat %0d drive %h, expected %h",
                                          beats_checked, rsp_drive, want.drive));
               end
               if (rsp_updated !== want.updated) begin
                  note_mismatch($sformatf("beat %0d updated %b, expected %b",
                                          beats_checked, rsp_updated, want.updated));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // reset values: manual hold, zero limits, 1000 ms sample period
   task automatic test_reset_defaults();
      send_beat(make_compute(32'sh0003_0000, 32'sh0001_0000, 32'd2000));
      send_beat(make_mode(1'b1, 32'sh0002_0000, 32'sh0040_0000));
      send_beat(make_compute(32'sh0003_0000, 32'sh0001_0000, 32'd999));
      send_beat(make_compute(32'sh0003_0000, 32'sh0001_0000, 32'd1000));
   endtask

   // mode changes, held output, seeding and its clamp
   task automatic test_bumpless_transfer();
      settle();
      load_settings(Q_ONE, 32'sh0000_8000, 32'sh0000_4000,
                    -32'sh0064_0000, 32'sh0064_0000, 32'd10);
      send_beat(make_mode(1'b0, 32'sh0001_0000, 32'sh0001_0000));
      // manual compute just repeats the held output
      send_beat(make_compute(32'sh000a_0000, 32'sh0005_0000, 32'd5000));
      // entry seed above out_max is clamped
      send_beat(make_mode(1'b1, 32'sh0005_0000, 32'sh00c8_0000));
      send_beat(make_compute(32'sh000a_0000, 32'sh0005_0000, 32'd5000));
      // too early for the next sample
      send_beat(make_compute(32'sh000a_0000, 32'sh0006_0000, 32'd5005));
      // already automatic: no reseed
      send_beat(make_mode(1'b1, 32'sh0050_0000, -32'sh0050_0000));
      send_beat(make_compute(32'sh000a_0000, 32'sh0007_0000, 32'd5015));
      send_beat(make_mode(1'b0, 32'sh0001_0000, 32'sh0001_0000));
      // entry seed below out_min is clamped
      send_beat(make_mode(1'b1, -32'sh0007_0000, -32'sh012c_0000));
      send_beat(make_compute(32'sh0002_0000, -32'sh0007_0000, 32'd5025));
   endtask

   // extreme gains and operands, zero sample period updates every time
   task automatic test_extreme_operands();
      settle();
      load_settings(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 32'd0);
      send_beat(make_compute(Q_MAX, Q_MIN, 32'h1234_5678));
      send_beat(make_compute(Q_MIN, Q_MAX, 32'h1234_5678));
      send_beat(make_compute(Q_MIN, Q_MIN, 32'h0000_0000));
      settle();
      load_settings(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'd0);
      send_beat(make_compute(Q_MAX, Q_MIN, 32'hffff_ffff));
      send_beat(make_mode(1'b0, Q_MAX, Q_MIN));
      send_beat(make_mode(1'b1, Q_MIN, Q_MAX));
   endtask

   // elapsed time across the 32-bit wrap
   task automatic test_time_wrap();
      settle();
      load_settings(Q_ONE, 32'sh0000_1000, 32'sh0000_2000,
                    -32'sh1000_0000, 32'sh1000_0000, 32'd1000);
      send_beat(make_compute(32'sh0001_0000, 32'sh0000_8000, 32'hffff_ff00));
      send_beat(make_compute(32'sh0001_0000, 32'sh0000_8000, 32'h0000_0100));
      send_beat(make_compute(32'sh0001_0000, 32'sh0000_8000, 32'h0000_02e8));
   endtask

   // out_min above out_max; stored state is not re-clamped by the writes
   task automatic test_inverted_limits();
      settle();
      load_settings(Q_ONE, Q_ONE, '0, 32'sh0032_0000, -32'sh0032_0000, 32'd1);
      send_beat(make_compute('0, '0, 32'h0000_1000));
      send_beat(make_compute(-32'sh00c8_0000, '0, 32'h0000_2000));
   endtask

   task automatic test_random_traffic();
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         if (phase == 0) begin
            load_settings(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 32'd1);
         end else if (phase == 1) begin
            load_settings(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 32'hffff_ffff);
         end else begin
            a = pick_q16();
            b = pick_q16();
            // mostly ordered limits, now and then inverted
            if ((a > b) != ($urandom_range(0, 7) == 0)) begin
               load_settings(pick_gain(), pick_gain(), pick_gain(), b, a, pick_period());
            end else begin
               load_settings(pick_gain(), pick_gain(), pick_gain(), a, b, pick_period());
            end
         end
         // every fourth phase runs with no gaps on either side
         idle_on = (phase % 4 != 3);
         ms_now  = $urandom;
         repeat (BEATS_PER_PHASE) send_beat(draw_request());
      end
      idle_on = 1'b1;
   endtask

   // result side held off long enough that the block fills and stalls req_*
   task automatic test_backpressure();
      settle();
      load_settings(32'sh0000_c000, 32'sh0000_2000, 32'sh0000_1000,
                    -32'sh0100_0000, 32'sh0100_0000, 32'd5);
      idle_on = 1'b0;
      ms_now  = $urandom;
      send_beat(make_mode(1'b1, pick_q16(), pick_q16()));
      fork
         begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
         begin
            repeat (20) send_beat(draw_request());
         end
      join
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_bumpless_transfer();
      test_extreme_operands();
      test_time_wrap();
      test_inverted_limits();
      test_random_traffic();
      test_backpressure();

      // drain, then wait for any stray beat
      settle();
      repeat (10) @(posedge clock);
      if (pending_drives.size() != 0) begin
         note_mismatch($sformatf("%0d expected result beats never arrived",
                                 pending_drives.size()));
      end

      $display("covered %0d request beats: %0d mode beats, %0d fresh updates, %0d settings",
               beats_sent, mode_beats, fresh_updates, settings_loaded);
      $display("checked %0d result beats, input stalled %0d cycles, %0d mismatches",
               beats_checked, input_stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("tb_pid_controller_bumpless OK");
      end else begin
         $display("tb_pid_controller_bumpless NOT OK");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #(4_000_000);
      $display("tb_pid_controller_bumpless NOT OK");
      $finish;
   end

endmodule

// File: pid_controller_bumpless.f
src/pidc_pkg.sv
src/pid_controller_bumpless.sv
src/pidc_checker.sv
dv/tb_pid_controller_bumpless.sv
